[hdl/pfd_pkg.sv]
// Shared types, codes and helper functions for the Playfair decipher block.
`default_nettype none

package pfd_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    localparam logic [4:0] IDX_I     = 5'd8;
    localparam logic [4:0] IDX_J     = 5'd9;
    localparam logic [4:0] LAST_CELL = 5'(CELLS - 1);
    localparam logic [4:0] LAST_LTR  = 5'(LETTERS - 1);
    localparam logic [2:0] LAST_RC   = 3'(SIDE - 1);

    localparam logic [7:0] ASCII_UA = 8'h41;
    localparam logic [7:0] ASCII_UZ = 8'h5A;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LZ = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_KEY     = 2'd1,
        ACT_END_KEY = 2'd2,
        ACT_DECRYPT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_ALPHA = 2'd1,
        STAT_NOT_READY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_READ1,
        ST_READ2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } letter_t;

    // Upper-case the byte, reject non-letters and fold J onto I.
    function automatic letter_t letter_index(input logic [7:0] b);
        letter_t    res;
        logic [7:0] v;
        v = b;
        if (v >= ASCII_LA && v <= ASCII_LZ)
        begin
            v = v - CASE_GAP;
        end
        res.ok  = (v >= ASCII_UA) && (v <= ASCII_UZ);
        res.idx = 5'(v - ASCII_UA);
        if (res.idx == IDX_J)
        begin
            res.idx = IDX_I;
        end
        return res;
    endfunction

    // Linear cell address of a row and column.
    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        return 5'({2'b00, row} * 5'(SIDE)) + {2'b00, col};
    endfunction

endpackage

`default_nettype wire

[hdl/playfair_decipher.sv]
// Top level of the Playfair decipher block: key square store, sequencer and result register.
`default_nettype none

// Playfair decipher with a 5x5 key square held in a 25-entry memory that has one
// registered read port and one write port. Every input transfer is one command:
// clear the square, add a key byte, end the key, or decrypt one digraph. Clear and
// key-byte commands finish in the cycle of their transfer. End of key walks the 26
// letters one per cycle and appends each unused one (J skipped). A decrypt command
// scans the square through the single read port to find both letters, then reads
// the two output letters one after the other; a digraph rejected for an unfinished
// square or a non-letter byte skips the scan and the reads. The input side stalls
// while a command is in progress. Each decrypt gives one result transfer, held in
// an output register; the block may take further commands while that result waits,
// and only stalls when a second result is ready before the first has been taken. A
// result carries zeros in both letters whenever its status is not OK.
module playfair_decipher (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] action,
    input  wire logic [7:0] key_byte,
    input  wire logic [7:0] cipher_first,
    input  wire logic [7:0] cipher_second,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      plain_first,
    output logic [7:0]      plain_second,
    output logic [1:0]      status
);
    import pfd_pkg::*;

    // Key square memory and its ports.
    logic [4:0] sq_mem [CELLS];
    logic       sq_we;
    logic [4:0] sq_waddr;
    logic [4:0] sq_wdata;
    logic [4:0] sq_raddr;
    logic [4:0] sq_rdata_reg;

    // Control state.
    state_t           state_reg, state_next;
    logic [LETTERS-1:0] used_reg, used_next;
    logic [4:0]       fill_reg, fill_next;
    logic             ready_reg, ready_next;
    logic [4:0]       k_reg, k_next;

    // Scan bookkeeping: the address issued and the cell whose data is now in sq_rdata_reg.
    logic [2:0] srow_reg, srow_next;
    logic [2:0] scol_reg, scol_next;
    logic [2:0] drow_reg, drow_next;
    logic [2:0] dcol_reg, dcol_next;
    logic       dvalid_reg, dvalid_next;
    logic       issued_all_reg, issued_all_next;

    // Digraph being decrypted and the positions found for it.
    logic [4:0] a_reg, a_next;
    logic [4:0] b_reg, b_next;
    logic [2:0] r1_reg, r1_next;
    logic [2:0] c1_reg, c1_next;
    logic [2:0] r2_reg, r2_next;
    logic [2:0] c2_reg, c2_next;
    logic [4:0] p1_reg, p1_next;
    status_t    res_status_reg, res_status_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] pf_reg, pf_next;
    logic [7:0] ps_reg, ps_next;
    status_t    st_reg, st_next;

    logic       in_xfer;
    letter_t    key_l;
    letter_t    c1_l;
    letter_t    c2_l;
    logic [2:0] o1_row, o1_col, o2_row, o2_col;
    logic [4:0] o1_addr, o2_addr;

    assign in_stall     = (state_reg != ST_IDLE);
    assign in_xfer      = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign plain_first  = pf_reg;
    assign plain_second = ps_reg;
    assign status       = st_reg;

    assign key_l = letter_index(key_byte);
    assign c1_l  = letter_index(cipher_first);
    assign c2_l  = letter_index(cipher_second);

    // Output cells: same row shifts left, same column shifts up, else swap the columns.
    always_comb
    begin
        if (r1_reg == r2_reg)
        begin
            o1_row = r1_reg;
            o2_row = r2_reg;
            o1_col = (c1_reg == 3'd0) ? LAST_RC : c1_reg - 3'd1;
            o2_col = (c2_reg == 3'd0) ? LAST_RC : c2_reg - 3'd1;
        end
        else if (c1_reg == c2_reg)
        begin
            o1_row = (r1_reg == 3'd0) ? LAST_RC : r1_reg - 3'd1;
            o2_row = (r2_reg == 3'd0) ? LAST_RC : r2_reg - 3'd1;
            o1_col = c1_reg;
            o2_col = c2_reg;
        end
        else
        begin
            o1_row = r1_reg;
            o2_row = r2_reg;
            o1_col = c2_reg;
            o2_col = c1_reg;
        end
        o1_addr = cell_addr(o1_row, o1_col);
        o2_addr = cell_addr(o2_row, o2_col);
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        fill_next       = fill_reg;
        ready_next      = ready_reg;
        k_next          = k_reg;
        srow_next       = srow_reg;
        scol_next       = scol_reg;
        drow_next       = drow_reg;
        dcol_next       = dcol_reg;
        dvalid_next     = 1'b0;
        issued_all_next = issued_all_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        r1_next         = r1_reg;
        c1_next         = c1_reg;
        r2_next         = r2_reg;
        c2_next         = c2_reg;
        p1_next         = p1_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pf_next         = pf_reg;
        ps_next         = ps_reg;
        st_next         = st_reg;
        sq_we           = 1'b0;
        sq_waddr        = fill_reg;
        sq_wdata        = k_reg;
        sq_raddr        = cell_addr(srow_reg, scol_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            used_next  = '0;
                            fill_next  = '0;
                            ready_next = 1'b0;
                        end
                        ACT_KEY:
                        begin
                            if (!ready_reg && key_l.ok && !used_reg[key_l.idx])
                            begin
                                used_next[key_l.idx] = 1'b1;
                                if (fill_reg <= LAST_CELL)
                                begin
                                    sq_we     = 1'b1;
                                    sq_wdata  = key_l.idx;
                                    fill_next = fill_reg + 5'd1;
                                end
                            end
                        end
                        ACT_END_KEY:
                        begin
                            if (!ready_reg)
                            begin
                                k_next     = '0;
                                state_next = ST_FILL;
                            end
                        end
                        ACT_DECRYPT:
                        begin
                            a_next = c1_l.idx;
                            b_next = c2_l.idx;
                            if (!ready_reg)
                            begin
                                res_status_next = STAT_NOT_READY;
                                state_next      = ST_DONE;
                            end
                            else if (!c1_l.ok || !c2_l.ok)
                            begin
                                res_status_next = STAT_NOT_ALPHA;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                res_status_next = STAT_OK;
                                srow_next       = '0;
                                scol_next       = '0;
                                issued_all_next = 1'b0;
                                state_next      = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_FILL:
            begin
                if (k_reg != IDX_J && !used_reg[k_reg])
                begin
                    used_next[k_reg] = 1'b1;
                    if (fill_reg <= LAST_CELL)
                    begin
                        sq_we     = 1'b1;
                        fill_next = fill_reg + 5'd1;
                    end
                end
                k_next = k_reg + 5'd1;
                if (k_reg == LAST_LTR)
                begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // Issue one address per cycle; the data of the previous one is compared now.
                if (!issued_all_reg)
                begin
                    dvalid_next = 1'b1;
                    drow_next   = srow_reg;
                    dcol_next   = scol_reg;
                    if (scol_reg == LAST_RC)
                    begin
                        scol_next = '0;
                        if (srow_reg == LAST_RC)
                        begin
                            issued_all_next = 1'b1;
                        end
                        else
                        begin
                            srow_next = srow_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        scol_next = scol_reg + 3'd1;
                    end
                end
                if (dvalid_reg)
                begin
                    if (sq_rdata_reg == a_reg)
                    begin
                        r1_next = drow_reg;
                        c1_next = dcol_reg;
                    end
                    if (sq_rdata_reg == b_reg)
                    begin
                        r2_next = drow_reg;
                        c2_next = dcol_reg;
                    end
                    if (drow_reg == LAST_RC && dcol_reg == LAST_RC)
                    begin
                        state_next = ST_READ1;
                    end
                end
            end

            ST_READ1:
            begin
                sq_raddr   = o1_addr;
                state_next = ST_READ2;
            end

            ST_READ2:
            begin
                sq_raddr   = o2_addr;
                p1_next    = sq_rdata_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Hold the second output cell on the read port until the result is loaded.
                sq_raddr = o2_addr;
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    st_next        = res_status_reg;
                    if (res_status_reg == STAT_OK)
                    begin
                        pf_next = ASCII_UA + {3'b000, p1_reg};
                        ps_next = ASCII_UA + {3'b000, sq_rdata_reg};
                    end
                    else
                    begin
                        pf_next = '0;
                        ps_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sq_we)
        begin
            sq_mem[sq_waddr] <= sq_wdata;
        end
        sq_rdata_reg <= sq_mem[sq_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            fill_reg       <= '0;
            ready_reg      <= 1'b0;
            dvalid_reg     <= 1'b0;
            issued_all_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            ready_reg      <= ready_next;
            dvalid_reg     <= dvalid_next;
            issued_all_reg <= issued_all_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        srow_reg       <= srow_next;
        scol_reg       <= scol_next;
        drow_reg       <= drow_next;
        dcol_reg       <= dcol_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        r1_reg         <= r1_next;
        c1_reg         <= c1_next;
        r2_reg         <= r2_next;
        c2_reg         <= c2_next;
        p1_reg         <= p1_next;
        res_status_reg <= res_status_next;
        pf_reg         <= pf_next;
        ps_reg         <= ps_next;
        st_reg         <= st_next;
    end

endmodule

`default_nettype wire

[bench/playfair_decipher_tb.sv]
// Self-checking testbench for the Playfair decipher block with its own key-square model.
module playfair_decipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    // Cycles without any transfer on either side before the run is declared hung.
    // The longest quiet stretch is the deliberate output hold-off below.
    localparam int QUIET_LIMIT = 4000;
    // The hold-off used to fill the block and force it to stall its input.
    localparam int HOLD_OFF_CYCLES = 400;
    // Extra wait after the last expected result, so that any late stray result shows up.
    localparam int DRAIN_CYCLES = 64;

    // One expected result transfer.
    typedef struct {
        logic [7:0] pf;
        logic [7:0] ps;
        status_t    st;
    } plain_pair_t;

    // All block inputs start at known values.
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic [1:0] action        = ACT_CLEAR;
    logic [7:0] key_byte      = 8'h00;
    logic [7:0] cipher_first  = 8'h00;
    logic [7:0] cipher_second = 8'h00;
    logic       out_stall     = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] plain_first;
    logic [7:0] plain_second;
    logic [1:0] status;

    // Idle percentages for the sending and receiving sides.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Set by a test to ask the receiver for a long hold-off of that many cycles.
    int stall_burst_req = 0;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Shadow copy of the key square and its bookkeeping.
    logic [4:0] key_sq [CELLS];
    logic       used [LETTERS];
    int         fill_pos;
    logic       sq_ready;

    // Plaintext pairs predicted but not yet seen on the output, oldest first.
    plain_pair_t pending_plain[$];

    playfair_decipher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .key_byte      (key_byte),
        .cipher_first  (cipher_first),
        .cipher_second (cipher_second),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .plain_first   (plain_first),
        .plain_second  (plain_second),
        .status        (status)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Returns {valid, index}: the byte upper-cased, J folded onto I, and the valid
    // bit low when the byte is not a letter at all.
    function automatic logic [5:0] letter_code(input logic [7:0] b);
        logic [7:0] u;
        logic [4:0] idx;
        u = b;
        if (u >= ASCII_LA && u <= ASCII_LZ)
        begin
            u = u - CASE_GAP;
        end
        if (u < ASCII_UA || u > ASCII_UZ)
        begin
            return 6'd0;
        end
        idx = 5'(u - ASCII_UA);
        if (idx == IDX_J)
        begin
            idx = IDX_I;
        end
        return {1'b1, idx};
    endfunction

    // First cell that holds the letter; cell zero when it is missing.
    function automatic int find_cell(input logic [4:0] idx);
        for (int k = 0; k < CELLS; k++)
        begin
            if (key_sq[k] == idx)
            begin
                return k;
            end
        end
        return 0;
    endfunction

    task automatic clear_square();
        for (int k = 0; k < CELLS; k++)
        begin
            key_sq[k] = 5'd0;
        end
        for (int k = 0; k < LETTERS; k++)
        begin
            used[k] = 1'b0;
        end
        fill_pos = 0;
        sq_ready = 1'b0;
    endtask

    // Appends a letter at the next free cell. Once the square is full the letter
    // is still marked as used.
    task automatic place_letter(input logic [4:0] idx);
        if (fill_pos < CELLS)
        begin
            key_sq[fill_pos] = idx;
            fill_pos++;
        end
        used[idx] = 1'b1;
    endtask

    // Applies one accepted command to the shadow square and queues the plaintext
    // pair that a decrypt command must produce.
    task automatic apply_command(input action_t a, input logic [7:0] k,
                                 input logic [7:0] c1, input logic [7:0] c2);
        logic [5:0]  la;
        logic [5:0]  lb;
        int          pa;
        int          pb;
        int          r1;
        int          col1;
        int          r2;
        int          col2;
        int          o1;
        int          o2;
        plain_pair_t res;
        case (a)
            ACT_CLEAR:
            begin
                clear_square();
            end
            ACT_KEY:
            begin
                // Non-letters, repeats and bytes after the end of key are dropped.
                la = letter_code(k);
                if (!sq_ready && la[5] && !used[la[4:0]])
                begin
                    place_letter(la[4:0]);
                end
            end
            ACT_END_KEY:
            begin
                // Fill the rest with the unused letters in order, J left out.
                if (!sq_ready)
                begin
                    for (int m = 0; m < LETTERS; m++)
                    begin
                        if (5'(m) != IDX_J && !used[m])
                        begin
                            place_letter(5'(m));
                        end
                    end
                    sq_ready = 1'b1;
                end
            end
            default:
            begin
                res.pf = 8'h00;
                res.ps = 8'h00;
                la = letter_code(c1);
                lb = letter_code(c2);
                // An unfinished square takes precedence over a bad cipher byte.
                if (!sq_ready)
                begin
                    res.st = STAT_NOT_READY;
                end
                else if (!la[5] || !lb[5])
                begin
                    res.st = STAT_NOT_ALPHA;
                end
                else
                begin
                    pa   = find_cell(la[4:0]);
                    pb   = find_cell(lb[4:0]);
                    r1   = pa / SIDE;
                    col1 = pa % SIDE;
                    r2   = pb / SIDE;
                    col2 = pb % SIDE;
                    if (r1 == r2)
                    begin
                        // Same row, which also covers two equal letters: step left.
                        o1 = r1 * SIDE + (col1 + SIDE - 1) % SIDE;
                        o2 = r2 * SIDE + (col2 + SIDE - 1) % SIDE;
                    end
                    else if (col1 == col2)
                    begin
                        // Same column: step up.
                        o1 = ((r1 + SIDE - 1) % SIDE) * SIDE + col1;
                        o2 = ((r2 + SIDE - 1) % SIDE) * SIDE + col2;
                    end
                    else
                    begin
                        // Rectangle: each letter keeps its row and takes the other column.
                        o1 = r1 * SIDE + col2;
                        o2 = r2 * SIDE + col1;
                    end
                    res.pf = ASCII_UA + 8'(key_sq[o1]);
                    res.ps = ASCII_UA + 8'(key_sq[o2]);
                    res.st = STAT_OK;
                end
                pending_plain.push_back(res);
            end
        endcase
    endtask

    // Offers one command, after a random number of idle cycles, and holds it until
    // the block takes it. Returns at the clock edge of the transfer, so the next
    // call drives its first value in the same step without a second assignment.
    task automatic send_command(input action_t a, input logic [7:0] k,
                                input logic [7:0] c1, input logic [7:0] c2);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= a;
        key_byte      <= k;
        cipher_first  <= c1;
        cipher_second <= c2;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        apply_command(a, k, c1, c2);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    // A random letter A to Z in either case, J included.
    function automatic logic [7:0] any_letter();
        logic [7:0] l;
        l = ASCII_UA + 8'($urandom_range(25));
        if ($urandom_range(1) == 1)
        begin
            l = l + CASE_GAP;
        end
        return l;
    endfunction

    function automatic logic [7:0] key_char();
        return ($urandom_range(99) < 85) ? any_letter() : any_byte();
    endfunction

    function automatic logic [7:0] cipher_char();
        return ($urandom_range(99) < 92) ? any_letter() : any_byte();
    endfunction

    // Receiver: random stalls, or a long hold-off when a test asks for one. The
    // hold-off is counted here so the sender keeps running meanwhile.
    initial
    begin
        int burst_left;
        burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_burst_req != 0)
            begin
                burst_left      = stall_burst_req;
                stall_burst_req = 0;
            end
            if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Every result transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        plain_pair_t exp_pair;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_plain.size() == 0)
            begin
                $error("result transfer with no decrypt pending: %h %h status %0d",
                       plain_first, plain_second, status);
                mismatch_count++;
            end
            else
            begin
                exp_pair = pending_plain.pop_front();
                if (plain_first !== exp_pair.pf)
                begin
                    $error("plain_first: expected %h, got %h", exp_pair.pf, plain_first);
                    mismatch_count++;
                end
                if (plain_second !== exp_pair.ps)
                begin
                    $error("plain_second: expected %h, got %h", exp_pair.ps, plain_second);
                    mismatch_count++;
                end
                if (status !== exp_pair.st)
                begin
                    $error("status: expected %0d, got %0d", exp_pair.st, status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither side has moved a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL playfair_decipher");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hand-picked commands. With the key "PLAYJ" the square reads
    //   P L A Y I / B C D E F / G H K M N / O Q R S T / U V W X Z
    // which gives known row, column and rectangle cases below.
    task automatic test_directed();
        // Decrypt straight after reset: the square is not finished.
        send_command(ACT_DECRYPT, 8'hFF, "A", "B");
        // Non-letter key bytes at both ends of the byte range are dropped.
        send_command(ACT_KEY, 8'h00, 8'hFF, 8'h00);
        send_command(ACT_KEY, 8'hFF, 8'h00, 8'hFF);
        // Lower case is folded up, J becomes I, and a repeated letter is dropped.
        send_command(ACT_KEY, "p", 8'h00, 8'h00);
        send_command(ACT_KEY, "L", 8'h00, 8'h00);
        send_command(ACT_KEY, "a", 8'h00, 8'h00);
        send_command(ACT_KEY, "Y", 8'h00, 8'h00);
        send_command(ACT_KEY, "j", 8'h00, 8'h00);
        send_command(ACT_KEY, "P", 8'h00, 8'h00);
        // Still unfinished, and that wins over the non-letter byte.
        send_command(ACT_DECRYPT, 8'h00, "A", 8'hFF);
        send_command(ACT_END_KEY, 8'h00, 8'h00, 8'h00);
        // A key byte and a second end of key on a ready square change nothing.
        send_command(ACT_KEY, "Q", 8'h00, 8'h00);
        send_command(ACT_END_KEY, 8'hFF, 8'hFF, 8'hFF);
        // Same row, then same row with wrap-around at the left edge.
        send_command(ACT_DECRYPT, 8'h00, "L", "Y");
        send_command(ACT_DECRYPT, 8'h00, "p", "i");
        // Same column, then same column with wrap-around at the top.
        send_command(ACT_DECRYPT, 8'h00, "C", "Q");
        send_command(ACT_DECRYPT, 8'h00, "L", "V");
        // Rectangle corners.
        send_command(ACT_DECRYPT, 8'h00, "B", "N");
        // Two equal letters act as the same row.
        send_command(ACT_DECRYPT, 8'h00, "E", "E");
        // Cipher J is looked up as I, lower case as upper.
        send_command(ACT_DECRYPT, 8'h00, "J", "x");
        // Bytes just outside both letter ranges, and the byte extremes.
        send_command(ACT_DECRYPT, 8'h00, 8'h40, 8'h5B);
        send_command(ACT_DECRYPT, 8'h00, 8'h60, "z");
        send_command(ACT_DECRYPT, 8'h00, "Z", 8'h7B);
        send_command(ACT_DECRYPT, 8'hFF, 8'h00, 8'hFF);
        // Clear empties the square again.
        send_command(ACT_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        send_command(ACT_DECRYPT, 8'h00, "A", "B");
    endtask

    // Builds a square, then holds the output for a long stretch while decrypts keep
    // coming, so that the result register fills and the input stalls.
    task automatic test_backpressure();
        send_command(ACT_CLEAR, any_byte(), any_byte(), any_byte());
        repeat (6)
        begin
            send_command(ACT_KEY, any_letter(), any_byte(), any_byte());
        end
        send_command(ACT_END_KEY, any_byte(), any_byte(), any_byte());
        stall_burst_req = HOLD_OFF_CYCLES;
        repeat (24)
        begin
            send_command(ACT_DECRYPT, any_byte(), any_letter(), any_letter());
        end
    endtask

    // Mostly well-formed sessions: clear, a key of random length, end of key and a
    // run of decrypts. Some sessions skip the clear or the end of key, some stray
    // key commands land on a ready square, and the rest is random commands.
    task automatic test_random(input int n_items);
        int sent;
        int key_len;
        int n_pairs;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(9) != 0)
                begin
                    send_command(ACT_CLEAR, any_byte(), any_byte(), any_byte());
                    sent++;
                end
                // Mostly short keys; now and then one long enough to fill the square.
                key_len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
                repeat (key_len)
                begin
                    send_command(ACT_KEY, key_char(), any_byte(), any_byte());
                    sent++;
                end
                if ($urandom_range(9) != 0)
                begin
                    send_command(ACT_END_KEY, any_byte(), any_byte(), any_byte());
                    sent++;
                end
                n_pairs = $urandom_range(1, 12);
                repeat (n_pairs)
                begin
                    case ($urandom_range(19))
                        0:
                        begin
                            send_command(ACT_KEY, key_char(), any_byte(), any_byte());
                        end
                        1:
                        begin
                            send_command(ACT_END_KEY, any_byte(), any_byte(), any_byte());
                        end
                        default:
                        begin
                            send_command(ACT_DECRYPT, any_byte(), cipher_char(), cipher_char());
                        end
                    endcase
                    sent++;
                end
            end
            else
            begin
                send_command(action_t'($urandom_range(3)), any_byte(), any_byte(), any_byte());
                sent++;
            end
        end
    endtask

    initial
    begin
        clear_square();
        repeat (2)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        // Sender idles rarely, receiver often.
        tx_idle_pct = 13;
        rx_idle_pct = 61;
        test_directed();
        test_backpressure();
        test_random(600);

        // The other way round.
        tx_idle_pct = 61;
        rx_idle_pct = 13;
        test_random(600);

        // Full speed on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(600);

        in_valid <= 1'b0;
        while (pending_plain.size() != 0)
        begin
            @(posedge clk);
        end
        // Give a stray late result time to show up.
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        if (mismatch_count == 0)
        begin
            $display("PASS playfair_decipher");
        end
        else
        begin
            $display("FAIL playfair_decipher");
        end
        $finish;
    end

endmodule
